>>> hw/rtl/dmwbc_pkg.sv
// shared types and constants for the direct-mapped write-back cache
// no dependencies; imported by direct_mapped_writeback_cache and the testbench
package dmwbc_pkg;

    // fixed widths of the byte memory and the stream payloads
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // access selector carried in s_tuser
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_WBACK,
        ST_FILL,
        ST_FINISH,
        ST_RESP
    } state_t;

endpackage

>>> hw/rtl/direct_mapped_writeback_cache.sv
// direct-mapped write-back write-allocate cache with its backing byte memory
// depends on dmwbc_pkg
//
// Usage: one access per slave transaction. s_tuser selects read or write,
// s_tdata carries the byte address and the byte to store. A read gives one
// master transaction with the byte, the hit flag and the line's dirty flag;
// a write gives none. LINE_COUNT and BYTES_PER_LINE are powers of two.
// Flow: s_tready is high only while the controller is idle, so accesses
// are handled one at a time. A write hit returns to idle from the lookup;
// a read hit passes through a response state first. A miss adds a line
// fill, preceded by a write-back when the victim line is valid and dirty;
// the data and backing memories each move one byte a cycle during these.
// Reset: all control state clears, then a clearing pass zeroes the
// backing memory and the tag store (one entry a cycle) while s_tready
// stays low.
// Stall: a result sits in the output register until taken; the next access
// is still accepted, and only a later read result waits in the controller.
module direct_mapped_writeback_cache
    import dmwbc_pkg::*;
#(
    parameter int LINE_COUNT     = 64,
    parameter int BYTES_PER_LINE = 4,
    parameter int TAG_BITS       = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // slave side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // address[15:0], write_byte[23:16]
    input  logic                 s_tuser,   // op
    // master side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // read_byte[7:0], was_hit[8], line_dirty[9]
);

    // derived geometry
    localparam int OFF_SH     = $clog2(BYTES_PER_LINE);
    localparam int IDX_SH     = $clog2(LINE_COUNT);
    localparam int OFF_W      = (OFF_SH > 0) ? OFF_SH : 1;
    localparam int IDX_W      = IDX_SH;
    localparam int DATA_DEPTH = LINE_COUNT * BYTES_PER_LINE;
    localparam int DA_W       = $clog2(DATA_DEPTH);
    localparam int CNT_W      = $clog2(BYTES_PER_LINE + 1);
    localparam int TW         = TAG_BITS + 2;
    localparam int V_BIT      = TAG_BITS + 1;
    localparam int D_BIT      = TAG_BITS;

    localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'(BYTES_PER_LINE - 1);
    localparam logic [ADDR_W-1:0] IDX_MASK = ADDR_W'(LINE_COUNT - 1);
    localparam logic [ADDR_W-1:0] TAG_MASK = ADDR_W'((32'd1 << TAG_BITS) - 32'd1);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(BYTES_PER_LINE);

    // byte position inside the data store
    function automatic logic [DA_W-1:0] data_addr(input logic [IDX_W-1:0] line,
                                                  input logic [31:0] idx);
        data_addr = DA_W'((32'(line) << OFF_SH) + idx);
    endfunction

    // byte address in the backing memory, wrapped to the address width
    function automatic logic [ADDR_W-1:0] mem_addr(input logic [TAG_BITS-1:0] tag,
                                                   input logic [IDX_W-1:0] line,
                                                   input logic [31:0] idx);
        mem_addr = ADDR_W'((((32'(tag) << IDX_SH) + 32'(line)) << OFF_SH) + idx);
    endfunction

    // storage
    logic [TW-1:0]     tag_mem  [LINE_COUNT];
    logic [BYTE_W-1:0] data_mem [DATA_DEPTH];
    logic [BYTE_W-1:0] back_mem [MEM_DEPTH];

    // memory port controls
    logic              tag_we, tag_re;
    logic [IDX_W-1:0]  tag_wa, tag_ra;
    logic [TW-1:0]     tag_wd, tag_rd_reg;
    logic              data_we, data_re;
    logic [DA_W-1:0]   data_wa, data_ra;
    logic [BYTE_W-1:0] data_wd, data_rd_reg;
    logic              back_we, back_re;
    logic [ADDR_W-1:0] back_wa, back_ra;
    logic [BYTE_W-1:0] back_wd, back_rd_reg;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // access payload
    logic                op_reg, op_next;
    logic [OFF_W-1:0]    off_reg, off_next;
    logic [IDX_W-1:0]    line_reg, line_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [TAG_BITS-1:0] old_tag_reg, old_tag_next;
    logic [BYTE_W-1:0]   wbyte_reg, wbyte_next;
    logic [BYTE_W-1:0]   res_byte_reg, res_byte_next;
    logic                res_hit_reg, res_hit_next;
    logic                res_dirty_reg, res_dirty_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic                out_hit_reg, out_hit_next;
    logic                out_dirty_reg, out_dirty_next;

    // address split of the incoming transaction
    logic [ADDR_W-1:0]   in_addr;
    logic [ADDR_W-1:0]   in_off16, in_line16, in_tag16;
    logic                in_fire;
    logic                hit;
    logic [31:0]         prev_idx;

    assign in_addr   = s_tdata[ADDR_W-1:0];
    assign in_off16  = in_addr & OFF_MASK;
    assign in_line16 = (in_addr >> OFF_SH) & IDX_MASK;
    assign in_tag16  = (in_addr >> (OFF_SH + IDX_SH)) & TAG_MASK;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign hit       = tag_rd_reg[V_BIT] && (tag_rd_reg[TAG_BITS-1:0] == tag_reg);
    assign prev_idx  = 32'(cnt_reg) - 32'd1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - BYTE_W - 2){1'b0}}, out_dirty_reg, out_hit_reg,
                       out_byte_reg};

    // controller: next state, memory ports and payload updates
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        op_next        = op_reg;
        off_next       = off_reg;
        line_next      = line_reg;
        tag_next       = tag_reg;
        old_tag_next   = old_tag_reg;
        wbyte_next     = wbyte_reg;
        res_byte_next  = res_byte_reg;
        res_hit_next   = res_hit_reg;
        res_dirty_next = res_dirty_reg;
        out_byte_next  = out_byte_reg;
        out_hit_next   = out_hit_reg;
        out_dirty_next = out_dirty_reg;
        tag_we  = 1'b0;
        tag_wa  = line_reg;
        tag_wd  = '0;
        tag_re  = 1'b0;
        tag_ra  = line_reg;
        data_we = 1'b0;
        data_wa = data_addr(line_reg, 32'(off_reg));
        data_wd = wbyte_reg;
        data_re = 1'b0;
        data_ra = data_addr(line_reg, 32'(off_reg));
        back_we = 1'b0;
        back_wa = clr_reg;
        back_wd = '0;
        back_re = 1'b0;
        back_ra = mem_addr(tag_reg, line_reg, 32'(cnt_reg));

        unique case (state_reg)
            ST_CLEAR:
            begin
                back_we = 1'b1;
                back_wa = clr_reg;
                back_wd = '0;
                if (32'(clr_reg) < LINE_COUNT)
                begin
                    tag_we = 1'b1;
                    tag_wa = clr_reg[IDX_W-1:0];
                    tag_wd = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = s_tuser;
                    off_next   = in_off16[OFF_W-1:0];
                    line_next  = in_line16[IDX_W-1:0];
                    tag_next   = in_tag16[TAG_BITS-1:0];
                    wbyte_next = s_tdata[ADDR_W +: BYTE_W];
                    tag_re     = 1'b1;
                    tag_ra     = in_line16[IDX_W-1:0];
                    data_re    = 1'b1;
                    data_ra    = data_addr(in_line16[IDX_W-1:0], 32'(in_off16));
                    state_next = ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                if (hit)
                begin
                    if (op_reg == OP_WRITE)
                    begin
                        data_we    = 1'b1;
                        tag_we     = 1'b1;
                        tag_wd     = {1'b1, 1'b1, tag_reg};
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        res_byte_next  = data_rd_reg;
                        res_hit_next   = 1'b1;
                        res_dirty_next = tag_rd_reg[D_BIT];
                        state_next     = ST_RESP;
                    end
                end
                else
                begin
                    old_tag_next = tag_rd_reg[TAG_BITS-1:0];
                    res_hit_next = 1'b0;
                    cnt_next     = '0;
                    if (tag_rd_reg[V_BIT] && tag_rd_reg[D_BIT])
                        state_next = ST_WBACK;
                    else
                        state_next = ST_FILL;
                end
            end

            // victim write-back: read byte cnt, store byte cnt-1
            ST_WBACK:
            begin
                if (cnt_reg != CNT_LAST)
                begin
                    data_re = 1'b1;
                    data_ra = data_addr(line_reg, 32'(cnt_reg));
                end
                if (cnt_reg != '0)
                begin
                    back_we = 1'b1;
                    back_wa = mem_addr(old_tag_reg, line_reg, prev_idx);
                    back_wd = data_rd_reg;
                end
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            // line fill: fetch byte cnt, store byte cnt-1
            ST_FILL:
            begin
                if (cnt_reg != CNT_LAST)
                begin
                    back_re = 1'b1;
                    back_ra = mem_addr(tag_reg, line_reg, 32'(cnt_reg));
                end
                if (cnt_reg != '0)
                begin
                    data_we = 1'b1;
                    data_wa = data_addr(line_reg, prev_idx);
                    data_wd = back_rd_reg;
                    if (prev_idx == 32'(off_reg))
                        res_byte_next = back_rd_reg;
                end
                if (cnt_reg == CNT_LAST)
                    state_next = ST_FINISH;
                else
                    cnt_next = cnt_reg + 1'b1;
            end

            ST_FINISH:
            begin
                tag_we = 1'b1;
                if (op_reg == OP_WRITE)
                begin
                    data_we    = 1'b1;
                    tag_wd     = {1'b1, 1'b1, tag_reg};
                    state_next = ST_IDLE;
                end
                else
                begin
                    tag_wd         = {1'b1, 1'b0, tag_reg};
                    res_dirty_next = 1'b0;
                    state_next     = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next  = 1'b1;
                    out_byte_next  = res_byte_reg;
                    out_hit_next   = res_hit_reg;
                    out_dirty_next = res_dirty_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        off_reg       <= off_next;
        line_reg      <= line_next;
        tag_reg       <= tag_next;
        old_tag_reg   <= old_tag_next;
        wbyte_reg     <= wbyte_next;
        res_byte_reg  <= res_byte_next;
        res_hit_reg   <= res_hit_next;
        res_dirty_reg <= res_dirty_next;
        out_byte_reg  <= out_byte_next;
        out_hit_reg   <= out_hit_next;
        out_dirty_reg <= out_dirty_next;
    end

    // tag store: valid, dirty and tag per line
    always_ff @(posedge clk)
    begin
        if (tag_we)
            tag_mem[tag_wa] <= tag_wd;
        if (tag_re)
            tag_rd_reg <= tag_mem[tag_ra];
    end

    // data store: line bytes
    always_ff @(posedge clk)
    begin
        if (data_we)
            data_mem[data_wa] <= data_wd;
        if (data_re)
            data_rd_reg <= data_mem[data_ra];
    end

    // backing byte memory
    always_ff @(posedge clk)
    begin
        if (back_we)
            back_mem[back_wa] <= back_wd;
        if (back_re)
            back_rd_reg <= back_mem[back_ra];
    end

endmodule

>>> bench/testbench.sv
// self-checking testbench for direct_mapped_writeback_cache: directed rows, then random accesses
// depends on dmwbc_pkg and the cache rtl; its own cache and memory predictor gives each read's expected result
`timescale 1ns / 1ps

module testbench;
    import dmwbc_pkg::*;

    // cache geometry at the default parameters
    localparam int OFF_W          = 2;
    localparam int LINE_W         = 6;
    localparam int TAG_W          = 8;
    localparam int LINES          = 1 << LINE_W;
    localparam int LINE_BYTES     = 1 << OFF_W;
    localparam int RANDOM_ITEMS   = 1830;
    localparam int PAUSE_AT       = 900;
    localparam int TAG_POOL       = 3;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4 * MEM_DEPTH + 10000;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              hit;
        logic              dirty;
    } read_result_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wbyte;
        logic              fixed;
        read_result_t      want;
    } stim_row_t;

    // directed rows: reset contents, address extremes, hits, misses and dirty evictions
    localparam int DIRECTED_ROWS = 22;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{OP_READ,  16'h0000, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'hFFFF, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h0000, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h0000, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{OP_WRITE, 16'h0001, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h0102, 8'hA5, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h0102, 8'h00, 1'b1, '{8'hA5, 1'b1, 1'b1}},
        '{OP_READ,  16'h0000, 8'h00, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{OP_READ,  16'h0001, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h0102, 8'h00, 1'b1, '{8'hA5, 1'b0, 1'b0}},
        '{OP_WRITE, 16'hFFFF, 8'h5A, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'hFFFC, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{OP_READ,  16'h00FF, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'hFFFF, 8'h00, 1'b1, '{8'h5A, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h8000, 8'h80, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h7FFF, 8'h7F, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h8000, 8'h00, 1'b1, '{8'h80, 1'b1, 1'b1}},
        '{OP_READ,  16'h7FFF, 8'h00, 1'b1, '{8'h7F, 1'b1, 1'b1}},
        '{OP_WRITE, 16'hAAAA, 8'h55, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_WRITE, 16'h5556, 8'hAA, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'hAAAA, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
        '{OP_READ,  16'h5556, 8'hFF, 1'b0, '{8'h00, 1'b0, 1'b0}}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // address[15:0], write_byte[23:16]
    logic                 s_tuser;   // op
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // read_byte[7:0], was_hit[8], line_dirty[9]

    // predictor state: line store and backing memory
    bit                 line_ok     [LINES];
    bit [TAG_W-1:0]     line_tag    [LINES];
    bit                 line_dirty  [LINES];
    bit [BYTE_W-1:0]    line_data   [LINES][LINE_BYTES];
    bit [BYTE_W-1:0]    memory_copy [MEM_DEPTH];
    bit [TAG_W-1:0]     tag_pool    [TAG_POOL];

    read_result_t expected_reads [$];

    int errors;
    int reads_sent;
    int writes_sent;
    int hits_seen;
    int writebacks_seen;
    int results_checked;
    int idle_cycles;
    int rx_phase_left;
    int rx_mode;

    direct_mapped_writeback_cache #(
        .LINE_COUNT     (LINES),
        .BYTES_PER_LINE (LINE_BYTES),
        .TAG_BITS       (TAG_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // write-back write-allocate access; returns 1 when a read result is due
    function automatic bit cache_access(input logic op, input logic [ADDR_W-1:0] addr,
                                        input logic [BYTE_W-1:0] wbyte,
                                        output read_result_t res, output bit hit);
        logic [OFF_W-1:0]  off;
        logic [LINE_W-1:0] idx;
        logic [TAG_W-1:0]  tag;
        int i;
        off = addr[OFF_W-1:0];
        idx = addr[OFF_W +: LINE_W];
        tag = addr[ADDR_W-1 -: TAG_W];
        hit = line_ok[idx] && line_tag[idx] == tag;
        res = '0;
        if (!hit)
        begin
            // evict a dirty victim under its old tag, then fill
            if (line_ok[idx] && line_dirty[idx])
            begin
                for (i = 0; i < LINE_BYTES; i++)
                    memory_copy[{line_tag[idx], idx, i[OFF_W-1:0]}] =
                        line_data[idx][i[OFF_W-1:0]];
                writebacks_seen++;
            end
            for (i = 0; i < LINE_BYTES; i++)
                line_data[idx][i[OFF_W-1:0]] = memory_copy[{tag, idx, i[OFF_W-1:0]}];
            line_tag[idx]   = tag;
            line_ok[idx]    = 1'b1;
            line_dirty[idx] = 1'b0;
        end
        if (op == OP_WRITE)
        begin
            line_data[idx][off] = wbyte;
            line_dirty[idx]     = 1'b1;
            return 1'b0;
        end
        res.data  = line_data[idx][off];
        res.hit   = hit;
        res.dirty = line_dirty[idx];
        return 1'b1;
    endfunction

    // drive one access and wait for its transaction, then record the expected read
    task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] wbyte, input logic fixed,
                               input read_result_t want);
        read_result_t res;
        bit           hit;
        bit           gives;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {wbyte, addr};
        do
            @(posedge clk);
        while (!s_tready);
        gives = cache_access(op, addr, wbyte, res, hit);
        if (gives)
            expected_reads.push_back(fixed ? want : res);
        if (op == OP_WRITE)
            writes_sent++;
        else
            reads_sent++;
        if (hit)
            hits_seen++;
    endtask

    task automatic hold_idle(input int n);
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
    endtask

    // mostly a small working set of tags so lines hit, conflict and evict
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [TAG_W-1:0]  t;
        logic [LINE_W-1:0] l;
        logic [OFF_W-1:0]  o;
        o = OFF_W'($urandom_range(0, LINE_BYTES - 1));
        t = tag_pool[$urandom_range(0, TAG_POOL - 1)];
        l = ($urandom_range(0, 1) == 0) ? LINE_W'($urandom_range(0, 7))
                                        : LINE_W'($urandom_range(0, LINES - 1));
        if ($urandom_range(0, 3) == 0)
            return ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
        return {t, l, o};
    endfunction

    // receiver: phases of full speed, random stalls and heavy back-pressure
    always @(negedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode       = $urandom_range(0, 2);
            rx_phase_left = $urandom_range(20, 200);
        end
        else
        begin
            rx_phase_left--;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // read result checker
    always @(posedge clk)
    begin
        read_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reads.size() == 0)
            begin
                report_mismatch($sformatf("read result %h with no read pending", m_tdata));
            end
            else
            begin
                want = expected_reads.pop_front();
                results_checked++;
                if (m_tdata[7:0] !== want.data)
                    report_mismatch($sformatf("read_byte got %h want %h",
                                              m_tdata[7:0], want.data));
                if (m_tdata[8] !== want.hit)
                    report_mismatch($sformatf("was_hit got %b want %b", m_tdata[8], want.hit));
                if (m_tdata[9] !== want.dirty)
                    report_mismatch($sformatf("line_dirty got %b want %b",
                                              m_tdata[9], want.dirty));
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int issued;
        int burst;
        int k;
        int r;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = OP_READ;
        s_tdata  = '0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_access(DIRECTED[r].op, DIRECTED[r].addr, DIRECTED[r].wbyte,
                        DIRECTED[r].fixed, DIRECTED[r].want);
            hold_idle($urandom_range(0, 2));
        end

        // random bursts with random gaps
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && issued < RANDOM_ITEMS; k++)
            begin
                if (issued % 150 == 0)
                begin
                    for (r = 0; r < TAG_POOL; r++)
                        tag_pool[r] = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
                end
                send_access(1'($urandom_range(0, 1)), pick_address(),
                            BYTE_W'($urandom_range(0, (1 << BYTE_W) - 1)), 1'b0, '0);
                issued++;
                // hold off once until every pending read has come back
                if (issued == PAUSE_AT)
                begin
                    hold_idle(1);
                    while (expected_reads.size() != 0)
                        @(posedge clk);
                end
            end
            hold_idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        hold_idle(1);

        // drain
        while (expected_reads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (expected_reads.size() != 0)
            report_mismatch($sformatf("%0d reads never answered", expected_reads.size()));

        $display("covered %0d reads and %0d writes: %0d hits, %0d misses, %0d dirty evictions",
                 reads_sent, writes_sent, hits_seen, reads_sent + writes_sent - hits_seen,
                 writebacks_seen);
        $display("%0d read results checked, %0d mismatches", results_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
